// ===== rtl/core/plrf_pkg.sv =====
// ----------------------------------------------------------------------------
// plrf_pkg : shared constants and table builder for the pixel light metrics
// Holds the code width and the elaboration-time sRGB linearization entry.
// ----------------------------------------------------------------------------
package plrf_pkg;

   localparam int CODE_W    = 8;
   localparam int NUM_CODES = 1 << CODE_W;

   // Highest code that still lies on the linear segment of the sRGB curve
   localparam int KNEE_CODE = 10;

   // Linear value of one gamma code in unsigned Q0.frac_bits, rounded to
   // nearest and saturated to all ones. Evaluated at elaboration only.
   function automatic longint lin_entry(input int frac_bits, input int code);
      longint one_q;
      longint val;
      real    base;
      real    lin;
      one_q = longint'(1) << frac_bits;
      if (code <= KNEE_CODE) begin
         // c / 255 / 12.92, kept in integers: 12.92 * 255 * 10 = 32946
         val = (longint'(10) * longint'(code) * one_q + 64'sd16473) / 64'sd32946;
      end else begin
         base = real'(1000 * code + 14025) / 269025.0;
         lin  = $pow(base, 2.4) * real'(one_q);
         val  = longint'($floor(lin + 0.5));
      end
      if (val > one_q - 1) begin
         val = one_q - 1;
      end
      return val;
   endfunction

endpackage

// ===== rtl/core/plrf_lin_rom.sv =====
// ----------------------------------------------------------------------------
// plrf_lin_rom : sRGB gamma code to linear light lookup
// Constant table of NUM_CODES entries built at elaboration, one read port.
// ----------------------------------------------------------------------------
module plrf_lin_rom
   import plrf_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic [CODE_W-1:0]    code,
   output logic [FRAC_BITS-1:0] lin
);

   logic [FRAC_BITS-1:0] rom [NUM_CODES];

   for (genvar i = 0; i < NUM_CODES; i++) begin : g_entry
      localparam longint ENTRY = lin_entry(FRAC_BITS, i);
      assign rom[i] = ENTRY[FRAC_BITS-1:0];
   end

   assign lin = rom[code];

endmodule

// ===== rtl/core/pixel_luma_red_flash_metrics.sv =====
// ----------------------------------------------------------------------------
// pixel_luma_red_flash_metrics : per-pixel luminance and red-flash metrics
//
// Takes one 8-bit sRGB pixel per word on the req_ channel and returns one
// word on the rsp_ channel: BT.709 relative luminance (Q0.FRAC_BITS,
// saturated), the red-flash value max(0, r-g-b)*320 and a saturated-red flag,
// all worked out on linear light.
//
// A word is taken at a clock edge with valid high and stall low. The accepting
// edge loads the first of three register stages, and rsp_valid rises once the
// word reaches the third; throughput is one pixel per clock while rsp_stall
// is low. The three stages are: table lookup, weight multipliers with the
// channel sums, and the final accumulate/shift-add.
//
// Each stage holds its own valid bit and only holds when it is full and the
// next stage cannot take its word, so empty stages keep filling while a
// finished result waits on rsp_stall. req_stall rises only once every stage
// is full and the output is stalled. Reset (synchronous, active high) empties
// the pipeline; no words are lost or repeated across a stall.
// ----------------------------------------------------------------------------
module pixel_luma_red_flash_metrics
   import plrf_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CODE_W-1:0]    req_red_in,
   input  logic [CODE_W-1:0]    req_green_in,
   input  logic [CODE_W-1:0]    req_blue_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [FRAC_BITS-1:0] rsp_luminance,
   output logic [FRAC_BITS+8:0] rsp_red_flash_value,
   output logic                 rsp_saturated_red
);

   // BT.709 weights in Q0.FRAC_BITS, rounded to nearest
   localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
   localparam longint WR_L    = (64'sd2126 * ONE_Q + 64'sd5000) / 64'sd10000;
   localparam longint WG_L    = (64'sd7152 * ONE_Q + 64'sd5000) / 64'sd10000;
   localparam longint WB_L    = (64'sd722 * ONE_Q + 64'sd5000) / 64'sd10000;
   localparam int     PROD_W  = 2 * FRAC_BITS;
   localparam int     ACC_W   = 2 * FRAC_BITS + 2;
   localparam int     SUM_W   = FRAC_BITS + 4;
   localparam int     FLASH_W = FRAC_BITS + 9;

   localparam logic [FRAC_BITS-1:0] WR = WR_L[FRAC_BITS-1:0];
   localparam logic [FRAC_BITS-1:0] WG = WG_L[FRAC_BITS-1:0];
   localparam logic [FRAC_BITS-1:0] WB = WB_L[FRAC_BITS-1:0];

   localparam logic [ACC_W-1:0]     ACC_HALF = ACC_W'(ONE_Q >> 1);
   localparam logic [FRAC_BITS-1:0] LUM_MAX  = '1;

   // ---------------------------------------------------------------------
   // Handshake: each stage advances when empty or when the next one moves
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in;
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready  = !s3_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign s1_valid_in = s1_ready ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: linearize the three channels through the constant table
   // ---------------------------------------------------------------------
   logic [FRAC_BITS-1:0] lin_r_in, lin_g_in, lin_b_in;
   logic [FRAC_BITS-1:0] lin_r_ff, lin_g_ff, lin_b_ff;

   plrf_lin_rom #(.FRAC_BITS(FRAC_BITS)) u_rom_r (.code(req_red_in),   .lin(lin_r_in));
   plrf_lin_rom #(.FRAC_BITS(FRAC_BITS)) u_rom_g (.code(req_green_in), .lin(lin_g_in));
   plrf_lin_rom #(.FRAC_BITS(FRAC_BITS)) u_rom_b (.code(req_blue_in),  .lin(lin_b_in));

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         lin_r_ff <= lin_r_in;
         lin_g_ff <= lin_g_in;
         lin_b_ff <= lin_b_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: weight products, red excess and the saturated-red compare
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0]    prod_r_in, prod_g_in, prod_b_in;
   logic [PROD_W-1:0]    prod_r_ff, prod_g_ff, prod_b_ff;
   logic [FRAC_BITS:0]   gb_sum;
   logic [SUM_W-1:0]     ch_sum;
   logic [SUM_W-1:0]     red_x5;
   logic [FRAC_BITS-1:0] excess_in, excess_ff;
   logic                 sat_in, sat_ff;

   always_comb begin
      prod_r_in = PROD_W'(lin_r_ff) * PROD_W'(WR);
      prod_g_in = PROD_W'(lin_g_ff) * PROD_W'(WG);
      prod_b_in = PROD_W'(lin_b_ff) * PROD_W'(WB);

      gb_sum = {1'b0, lin_g_ff} + {1'b0, lin_b_ff};
      // Drop to zero unless red exceeds green plus blue
      if ({1'b0, lin_r_ff} > gb_sum) begin
         excess_in = lin_r_ff - gb_sum[FRAC_BITS-1:0];
      end else begin
         excess_in = '0;
      end

      ch_sum = SUM_W'(gb_sum) + SUM_W'(lin_r_ff);
      red_x5 = (SUM_W'(lin_r_ff) << 2) + SUM_W'(lin_r_ff);
      sat_in = (ch_sum != '0) && (red_x5 >= (ch_sum << 2));
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         prod_r_ff <= prod_r_in;
         prod_g_ff <= prod_g_in;
         prod_b_ff <= prod_b_in;
         excess_ff <= excess_in;
         sat_ff    <= sat_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: accumulate, round, saturate; flash gain of 320 = 256 + 64
   // ---------------------------------------------------------------------
   logic [ACC_W-1:0]          acc;
   logic [ACC_W-FRAC_BITS-1:0] lum_wide;
   logic [FRAC_BITS-1:0]      lum_in, lum_ff;
   logic [FLASH_W-1:0]        flash_in, flash_ff;
   logic                      sat_out_ff;

   always_comb begin
      acc      = ACC_W'(prod_r_ff) + ACC_W'(prod_g_ff) + ACC_W'(prod_b_ff) + ACC_HALF;
      lum_wide = acc[ACC_W-1:FRAC_BITS];
      if (lum_wide > (ACC_W-FRAC_BITS)'(LUM_MAX)) begin
         lum_in = LUM_MAX;
      end else begin
         lum_in = lum_wide[FRAC_BITS-1:0];
      end
      flash_in = (FLASH_W'(excess_ff) << 8) + (FLASH_W'(excess_ff) << 6);
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         lum_ff     <= lum_in;
         flash_ff   <= flash_in;
         sat_out_ff <= sat_ff;
      end
   end

   assign rsp_valid           = s3_valid_ff;
   assign rsp_luminance       = lum_ff;
   assign rsp_red_flash_value = flash_ff;
   assign rsp_saturated_red   = sat_out_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // An empty output stage must never push back on the input
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !s3_valid_ff |-> !req_stall)
      else $error("input stalled while output stage empty");

   // A full middle stage behind a stalled output keeps its word
   a_mid_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s3_valid_ff && rsp_stall |=>
         s2_valid_ff && $stable(excess_ff) && $stable(prod_g_ff))
      else $error("middle stage word lost under stall");

   // Gain of 320 leaves the low six bits clear
   a_flash_gain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red_flash_value[5:0] == 6'd0)
      else $error("red-flash value not a multiple of 64");

endmodule
